// ===== rtl/core/ps2sc_pkg.sv =====
// Package for the PS/2 set-2 scan code to ASCII converter.
// Holds the flag record type, prefix and shift codes and the character tables.
// No dependencies.
package ps2sc_pkg;

  localparam int CODE_W   = 8;
  localparam int CHAR_W   = 7;
  localparam int MAP_SIZE = 128;

  // Scan code constants
  localparam logic [CODE_W-1:0] PFX_BREAK    = 8'hF0;
  localparam logic [CODE_W-1:0] PFX_EXTENDED = 8'hE0;
  localparam logic [CODE_W-1:0] CODE_LSHIFT  = 8'h12;
  localparam logic [CODE_W-1:0] CODE_RSHIFT  = 8'h59;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;

  // Keyboard state record, kept in the state memory
  typedef struct packed {
    logic brk;  // break prefix seen
    logic ext;  // extended prefix seen
    logic lsh;  // left shift held
    logic rsh;  // right shift held
  } ps2sc_flags_t;

  localparam int FLAGS_W     = $bits(ps2sc_flags_t);
  localparam int STATE_DEPTH = 1;

  typedef logic [CHAR_W-1:0] char_map_t [MAP_SIZE];

  // Unshifted character table
  localparam char_map_t CHAR_MAP_LO = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h09, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h71, 7'h31, 7'h00,
    7'h00, 7'h00, 7'h7a, 7'h73, 7'h61, 7'h77, 7'h32, 7'h00,
    7'h00, 7'h63, 7'h78, 7'h64, 7'h65, 7'h34, 7'h33, 7'h00,
    7'h00, 7'h20, 7'h76, 7'h66, 7'h74, 7'h72, 7'h35, 7'h00,
    7'h00, 7'h6e, 7'h62, 7'h68, 7'h67, 7'h79, 7'h36, 7'h00,
    7'h00, 7'h00, 7'h6d, 7'h6a, 7'h75, 7'h37, 7'h38, 7'h00,
    7'h00, 7'h2c, 7'h6b, 7'h69, 7'h6f, 7'h30, 7'h39, 7'h00,
    7'h00, 7'h2e, 7'h2f, 7'h6c, 7'h3b, 7'h70, 7'h2d, 7'h00,
    7'h00, 7'h5c, 7'h3a, 7'h00, 7'h40, 7'h5e, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h0d, 7'h5b, 7'h00, 7'h5d, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00,
    7'h00, 7'h00, 7'h5c, 7'h1d, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h7f, 7'h1f, 7'h00, 7'h1c, 7'h1e, 7'h1b, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Shifted character table
  localparam char_map_t CHAR_MAP_HI = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h09, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h51, 7'h21, 7'h00,
    7'h00, 7'h00, 7'h5a, 7'h53, 7'h41, 7'h57, 7'h22, 7'h00,
    7'h00, 7'h43, 7'h58, 7'h44, 7'h45, 7'h24, 7'h23, 7'h00,
    7'h00, 7'h20, 7'h56, 7'h46, 7'h54, 7'h52, 7'h25, 7'h00,
    7'h00, 7'h4e, 7'h42, 7'h48, 7'h47, 7'h59, 7'h26, 7'h00,
    7'h00, 7'h00, 7'h4d, 7'h4a, 7'h55, 7'h27, 7'h28, 7'h00,
    7'h00, 7'h3c, 7'h4b, 7'h49, 7'h4f, 7'h00, 7'h29, 7'h00,
    7'h00, 7'h3e, 7'h3f, 7'h4c, 7'h2b, 7'h50, 7'h3d, 7'h00,
    7'h00, 7'h5f, 7'h2a, 7'h00, 7'h60, 7'h7e, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h0d, 7'h7b, 7'h00, 7'h7d, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08, 7'h00,
    7'h00, 7'h00, 7'h7c, 7'h1d, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h7f, 7'h1f, 7'h00, 7'h1c, 7'h1e, 7'h1b, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Table lookup, half picked by shift
  function automatic logic [CHAR_W-1:0] char_lookup(input logic shift,
                                                    input logic [6:0] idx);
    char_lookup = shift ? CHAR_MAP_HI[idx] : CHAR_MAP_LO[idx];
  endfunction

endpackage

// ===== rtl/core/ps2sc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the converter's state store. No dependencies.
module ps2sc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ps2sc_decode.sv =====
// Scan code decode: prefix and shift tracking plus character table lookup.
// Pure combinational; depends on ps2sc_pkg.
module ps2sc_decode
  import ps2sc_pkg::*;
(
  input  logic [CODE_W-1:0] code,
  input  ps2sc_flags_t      flags,
  output ps2sc_flags_t      flags_next,
  output logic              emit,
  output logic [CHAR_W-1:0] char_out
);

  // Flag update and lookup for one scan code
  always_comb begin
    flags_next = flags;
    char_out   = CHAR_NONE;
    if (code == PFX_BREAK) begin
      flags_next.brk = 1'b1;
    end else if (code == PFX_EXTENDED) begin
      flags_next.ext = 1'b1;
    end else begin
      if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
        // extended shift codes leave the shift state alone
        if (!flags.ext) begin
          if (code == CODE_LSHIFT) begin
            flags_next.lsh = !flags.brk;
          end else begin
            flags_next.rsh = !flags.brk;
          end
        end
      end else if (!flags.brk && !code[CODE_W-1]) begin
        char_out = char_lookup(flags.lsh || flags.rsh, code[6:0]);
      end
      flags_next.brk = 1'b0;
      flags_next.ext = 1'b0;
    end
  end

  assign emit = (char_out != CHAR_NONE);

endmodule

// ===== rtl/core/ps2_scancode_to_ascii.sv =====
// Path: decode stage register, then output register; m_tvalid rises only for a character.
// Throughput: one scan code per cycle unless the output stalls; set by the read-modify-write
// of the state memory, with the last write forwarded so back-to-back codes see fresh flags.
// Reset: synchronous; a clearing pass after rst falls zeroes the state memory, s_tready low.
// Depends on ps2sc_pkg, ps2sc_ram and ps2sc_decode.
module ps2_scancode_to_ascii
  import ps2sc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] scan_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [6:0] ascii_char, [7] zero
);

  localparam int AW = STATE_DEPTH > 1 ? $clog2(STATE_DEPTH) : 1;
  localparam logic [AW-1:0] STATE_ADDR = '0;

  logic              clear_busy;
  logic              s1_valid;
  logic [CODE_W-1:0] s1_code;
  logic              s1_adv;
  logic              s1_fire;
  logic              we;
  ps2sc_flags_t      wdata;
  ps2sc_flags_t      rdata;
  logic              wr_pend;
  ps2sc_flags_t      wr_data_q;
  ps2sc_flags_t      cur_flags;
  ps2sc_flags_t      flags_next;
  logic              emit;
  logic [CHAR_W-1:0] char_out;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;

  // Handshake
  assign s1_adv   = !out_valid || m_tready;
  assign s1_fire  = s1_valid && s1_adv;
  assign s_tready = !clear_busy && (!s1_valid || s1_adv);

  // State memory, read every cycle
  ps2sc_ram #(
    .WIDTH (FLAGS_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (STATE_ADDR),
    .wdata (wdata),
    .raddr (STATE_ADDR),
    .rdata (rdata)
  );

  // Forward the write of the previous cycle past the memory
  assign cur_flags = wr_pend ? wr_data_q : rdata;

  ps2sc_decode u_decode (
    .code       (s1_code),
    .flags      (cur_flags),
    .flags_next (flags_next),
    .emit       (emit),
    .char_out   (char_out)
  );

  // Write back: clearing pass after reset, otherwise the decoded flags
  assign we    = clear_busy || s1_fire;
  assign wdata = clear_busy ? ps2sc_flags_t'('0) : flags_next;

  // Clearing pass and forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      wr_pend    <= 1'b0;
    end else begin
      clear_busy <= 1'b0;
      wr_pend    <= we;
    end
    wr_data_q <= wdata;
  end

  // Decode stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      s1_code <= s_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      out_char <= char_out;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};

  // Assertions
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_tready && we)
    else $error("state clearing pass missing after reset");

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char != CHAR_NONE)
    else $error("zero character transferred");

  a_prefix_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_code != PFX_BREAK && s1_code != PFX_EXTENDED
      |=> wr_pend && !wr_data_q.brk && !wr_data_q.ext)
    else $error("prefix flags not cleared after non-prefix code");

  a_no_write_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready && !clear_busy |-> !we)
    else $error("state written while output stalled");

endmodule

// ===== verif/ps2sc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the PS/2 scan code to ASCII converter: watches both stream channels,
// tracks the keyboard flags, predicts each character and compares. Uses ps2sc_pkg.
module ps2sc_checker
  import ps2sc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] scan_code
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [6:0] ascii_char, [7] zero
  output int         fail_count,
  output int         pending
);

  ps2sc_flags_t        kb;
  logic [CHAR_W-1:0]   char_q[$];

  // Set-2 keymap: {shifted, plain} per code, zero where the key has no character
  function automatic logic [CHAR_W-1:0] key_char(input logic shift, input logic [6:0] code);
    logic [2*CHAR_W-1:0] pair;
    case (code)
      7'h0d: pair = {7'h09, 7'h09};
      7'h15: pair = {7'h51, 7'h71};
      7'h16: pair = {7'h21, 7'h31};
      7'h1a: pair = {7'h5a, 7'h7a};
      7'h1b: pair = {7'h53, 7'h73};
      7'h1c: pair = {7'h41, 7'h61};
      7'h1d: pair = {7'h57, 7'h77};
      7'h1e: pair = {7'h22, 7'h32};
      7'h21: pair = {7'h43, 7'h63};
      7'h22: pair = {7'h58, 7'h78};
      7'h23: pair = {7'h44, 7'h64};
      7'h24: pair = {7'h45, 7'h65};
      7'h25: pair = {7'h24, 7'h34};
      7'h26: pair = {7'h23, 7'h33};
      7'h29: pair = {7'h20, 7'h20};
      7'h2a: pair = {7'h56, 7'h76};
      7'h2b: pair = {7'h46, 7'h66};
      7'h2c: pair = {7'h54, 7'h74};
      7'h2d: pair = {7'h52, 7'h72};
      7'h2e: pair = {7'h25, 7'h35};
      7'h31: pair = {7'h4e, 7'h6e};
      7'h32: pair = {7'h42, 7'h62};
      7'h33: pair = {7'h48, 7'h68};
      7'h34: pair = {7'h47, 7'h67};
      7'h35: pair = {7'h59, 7'h79};
      7'h36: pair = {7'h26, 7'h36};
      7'h3a: pair = {7'h4d, 7'h6d};
      7'h3b: pair = {7'h4a, 7'h6a};
      7'h3c: pair = {7'h55, 7'h75};
      7'h3d: pair = {7'h27, 7'h37};
      7'h3e: pair = {7'h28, 7'h38};
      7'h41: pair = {7'h3c, 7'h2c};
      7'h42: pair = {7'h4b, 7'h6b};
      7'h43: pair = {7'h49, 7'h69};
      7'h44: pair = {7'h4f, 7'h6f};
      7'h45: pair = {7'h00, 7'h30};  // '0' has no shifted character
      7'h46: pair = {7'h29, 7'h39};
      7'h49: pair = {7'h3e, 7'h2e};
      7'h4a: pair = {7'h3f, 7'h2f};
      7'h4b: pair = {7'h4c, 7'h6c};
      7'h4c: pair = {7'h2b, 7'h3b};
      7'h4d: pair = {7'h50, 7'h70};
      7'h4e: pair = {7'h3d, 7'h2d};
      7'h51: pair = {7'h5f, 7'h5c};
      7'h52: pair = {7'h2a, 7'h3a};
      7'h54: pair = {7'h60, 7'h40};
      7'h55: pair = {7'h7e, 7'h5e};
      7'h5a: pair = {7'h0d, 7'h0d};
      7'h5b: pair = {7'h7b, 7'h5b};
      7'h5d: pair = {7'h7d, 7'h5d};
      7'h66: pair = {7'h08, 7'h08};
      7'h6a: pair = {7'h7c, 7'h5c};
      7'h6b: pair = {7'h1d, 7'h1d};
      7'h71: pair = {7'h7f, 7'h7f};
      7'h72: pair = {7'h1f, 7'h1f};
      7'h74: pair = {7'h1c, 7'h1c};
      7'h75: pair = {7'h1e, 7'h1e};
      7'h76: pair = {7'h1b, 7'h1b};
      default: pair = '0;
    endcase
    return shift ? pair[2*CHAR_W-1:CHAR_W] : pair[CHAR_W-1:0];
  endfunction

  // Advance the keyboard flags by one scan code, queue a character if one is due
  task automatic decode_scan(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CHAR_NONE;
    if (code == PFX_BREAK) begin
      kb.brk = 1'b1;
    end else if (code == PFX_EXTENDED) begin
      kb.ext = 1'b1;
    end else begin
      if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
        // extended shift codes leave the shift flags alone
        if (!kb.ext) begin
          if (code == CODE_LSHIFT) kb.lsh = !kb.brk;
          else                     kb.rsh = !kb.brk;
        end
      end else if (!kb.brk && !code[7]) begin
        ch = key_char(kb.lsh || kb.rsh, code[6:0]);
      end
      kb.brk = 1'b0;
      kb.ext = 1'b0;
      if (ch != CHAR_NONE) char_q.push_back(ch);
    end
  endtask

  // Watch both channels: predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    if (rst) begin
      kb         = '0;
      char_q     = {};
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (s_tvalid && s_tready) decode_scan(s_tdata);
      if (m_tvalid && m_tready) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected character, expected none, got %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          if (m_tdata !== {1'b0, char_q[0]}) begin
            $display("%0t: ascii_char mismatch, expected %h, got %h",
                     $time, {1'b0, char_q[0]}, m_tdata);
            fail_count <= fail_count + 1;
          end
          void'(char_q.pop_front());
        end
      end
      pending <= char_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for ps2_scancode_to_ascii: clock, reset, scan code stimulus and
// random back-pressure. Checking is done in ps2sc_checker. Uses ps2sc_pkg.
module tb;
  import ps2sc_pkg::*;

  localparam int NUM_CODES   = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 29;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       quiet    = 1'b0;   // no idling on either side while set
  int         fail_count;
  int         pending;
  int         sent_count  = 0;
  int         cycle_count = 0;

  always #5 clk = ~clk;

  ps2_scancode_to_ascii i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ps2sc_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver stalls at random
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // One scan code transfer, with random idle cycles ahead of it
  task automatic send_code(input logic [CODE_W-1:0] code);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
    quiet = (sent_count >= 500 && sent_count < 700);
  endtask

  // Key press and optional release, with optional extended prefix
  task automatic send_key(input logic [CODE_W-1:0] code, input logic ext, input logic rel);
    if (ext) send_code(PFX_EXTENDED);
    send_code(code);
    if (rel) begin
      if (ext) send_code(PFX_EXTENDED);
      send_code(PFX_BREAK);
      send_code(code);
    end
  endtask

  logic [CODE_W-1:0] directed_codes [26] = '{
    8'h00, 8'h7f, 8'h80, 8'hff, 8'h1c,          // extremes, plain key
    PFX_BREAK, PFX_BREAK, 8'h1c,                // repeated break prefix
    CODE_LSHIFT, 8'h1c, 8'h45,                  // shifted key, shifted unmapped
    PFX_EXTENDED, PFX_BREAK, CODE_LSHIFT, 8'h15,// extended shift break keeps shift
    PFX_BREAK, CODE_LSHIFT,                     // left shift released
    CODE_RSHIFT, 8'h16,                         // right shift
    PFX_EXTENDED, CODE_RSHIFT,                  // extended shift make ignored
    PFX_BREAK, CODE_RSHIFT,                     // right shift released
    PFX_EXTENDED, PFX_EXTENDED, 8'h75           // repeated extended prefix
  };

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed codes
    foreach (directed_codes[i]) send_code(directed_codes[i]);

    // Random keystrokes, mostly well formed, some noise
    while (sent_count < NUM_CODES) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_key(CODE_W'($urandom_range(127)), ($urandom_range(99) < 15),
                 1'($urandom_range(1)));
      end else if (r < 60) begin
        if ($urandom_range(99) < 10) send_code(PFX_EXTENDED);
        if ($urandom_range(1)) send_code(PFX_BREAK);
        send_code($urandom_range(1) ? CODE_LSHIFT : CODE_RSHIFT);
      end else if (r < 70) begin
        send_code(PFX_BREAK);
        send_code(CODE_W'($urandom_range(255)));
      end else if (r < 80) begin
        send_code(PFX_EXTENDED);
        send_code(CODE_W'($urandom_range(255)));
      end else begin
        send_code(CODE_W'($urandom_range(255)));
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding characters, then allow for the pipeline latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
